/* hdl/inv3_pkg.sv */
package inv3_pkg;

    localparam int ENT_W  = 16;                  // Q8.8 entry
    localparam int PRD_W  = 2 * ENT_W;           // entry product
    localparam int COF_W  = PRD_W + 1;           // cofactor, Q16.16 scale 2^16
    localparam int DET_W  = ENT_W + COF_W + 2;   // sum of three products
    localparam int RES_W  = 32;                  // Q16.16 result
    localparam int FRAC_SH = 24;                 // numerator pre-shift
    localparam int NUM_W  = COF_W + FRAC_SH;     // numerator magnitude
    localparam int DEN_W  = DET_W;               // denominator magnitude
    localparam int WIDE_W = DEN_W + RES_W + 1;   // compare width
    localparam int DIV_LAT = RES_W + 3;          // divider lane depth
    localparam int COF_LAT = 2;                  // cofactor lane depth
    localparam int DET_LAT = 2;                  // determinant products + sum
    localparam int TOT_LAT = COF_LAT + DET_LAT + DIV_LAT;

    localparam logic [RES_W-1:0] POS_SAT = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] NEG_SAT = {1'b1, {(RES_W-1){1'b0}}};

    typedef struct packed {
        logic signed [ENT_W-1:0] e00, e01, e02;
        logic signed [ENT_W-1:0] e10, e11, e12;
        logic signed [ENT_W-1:0] e20, e21, e22;
    } t_item;

    typedef struct packed {
        logic signed [RES_W-1:0] r00, r01, r02;
        logic signed [RES_W-1:0] r10, r11, r12;
        logic signed [RES_W-1:0] r20, r21, r22;
        logic                    singular;
    } t_result;

endpackage

/* hdl/inv3_cof.sv */
module inv3_cof (
    input  logic                                 i_clk,
    input  logic signed [inv3_pkg::ENT_W-1:0]    i_a,
    input  logic signed [inv3_pkg::ENT_W-1:0]    i_b,
    input  logic signed [inv3_pkg::ENT_W-1:0]    i_c,
    input  logic signed [inv3_pkg::ENT_W-1:0]    i_d,
    output logic signed [inv3_pkg::COF_W-1:0]    o_cof
);
    import inv3_pkg::*;

    logic signed [PRD_W-1:0] r_p0, r_p1;
    logic signed [COF_W-1:0] r_cof;

    // a*b - c*d: the products are registered first, then their difference is registered
    always_ff @(posedge i_clk) begin
        r_p0  <= PRD_W'(i_a) * PRD_W'(i_b);
        r_p1  <= PRD_W'(i_c) * PRD_W'(i_d);
        r_cof <= COF_W'(r_p0) - COF_W'(r_p1);
    end

    assign o_cof = r_cof;

endmodule

/* hdl/inv3_div.sv */
module inv3_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic signed [inv3_pkg::COF_W-1:0]    i_num,
    input  logic signed [inv3_pkg::DET_W-1:0]    i_den,
    output logic        [inv3_pkg::RES_W-1:0]    o_q
);
    import inv3_pkg::*;

    localparam int NST = RES_W + 1;

    logic [NUM_W-1:0] r_n;
    logic [DEN_W-1:0] r_dm;
    logic             r_neg, r_zero;

    logic [NUM_W-1:0] r_rem  [NST];
    logic [DEN_W-1:0] r_d    [NST];
    logic [RES_W-1:0] r_qp   [NST];
    logic             r_ng   [NST];
    logic             r_zr   [NST];
    logic             r_h    [NST];
    logic [RES_W-1:0] r_q;
    logic             r_hs;      // last stage saturated, for checking

    logic [COF_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
    assign num_mag = i_num[COF_W-1] ? COF_W'(-i_num) : COF_W'(i_num);
    assign den_mag = i_den[DET_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);

    // take magnitudes, sign and the zero-divisor flag
    always_ff @(posedge i_clk) begin
        r_n    <= {num_mag, {FRAC_SH{1'b0}}};
        r_dm   <= den_mag;
        r_neg  <= i_num[COF_W-1] ^ i_den[DET_W-1];
        r_zero <= (i_den == '0);
    end

    // load stage 0 and flag a quotient of 2^32 or more
    always_ff @(posedge i_clk) begin
        r_rem[0] <= r_n;
        r_d[0]   <= r_dm;
        r_qp[0]  <= '0;
        r_ng[0]  <= r_neg;
        r_zr[0]  <= r_zero;
        r_h[0]   <= WIDE_W'(r_n) >= (WIDE_W'(r_dm) << RES_W);
    end

    // one restoring step per stage, most significant bit first
    for (genvar s = 1; s < NST; s++) begin : g_step
        localparam int K = RES_W - s;
        logic [WIDE_W-1:0] dsh;
        logic              ge;
        assign dsh = WIDE_W'(r_d[s-1]) << K;
        assign ge  = WIDE_W'(r_rem[s-1]) >= dsh;
        always_ff @(posedge i_clk) begin
            r_rem[s] <= ge ? NUM_W'(WIDE_W'(r_rem[s-1]) - dsh) : r_rem[s-1];
            r_qp[s]  <= r_qp[s-1] | (RES_W'(ge) << K);
            r_d[s]   <= r_d[s-1];
            r_ng[s]  <= r_ng[s-1];
            r_zr[s]  <= r_zr[s-1];
            r_h[s]   <= r_h[s-1];
        end
    end

    logic [RES_W-1:0] qf;
    logic             pos_ovf, neg_ovf;
    assign qf      = r_qp[NST-1];
    assign pos_ovf = r_h[NST-1] | qf[RES_W-1];
    assign neg_ovf = r_h[NST-1] | (qf > NEG_SAT);

    // sign, saturate, zero for a singular matrix
    always_ff @(posedge i_clk) begin
        if (r_zr[NST-1]) begin
            r_q <= '0;
        end else if (r_ng[NST-1]) begin
            r_q <= neg_ovf ? NEG_SAT : RES_W'(-qf);
        end else begin
            r_q <= pos_ovf ? POS_SAT : qf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hs <= 1'b0;
        end else begin
            r_hs <= r_h[NST-1] & ~r_zr[NST-1];
        end
    end

    assign o_q = r_q;

    a_hsat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hs |-> (r_q == POS_SAT || r_q == NEG_SAT))
        else $error("quotient overflow did not saturate");

endmodule

/* hdl/invert_3x3_matrix.sv */
// Channel   Dir  Beat marker       Payload
// item      in   i_start & !o_busy i_item   (t_item, nine Q8.8 entries)
// result    out  o_done            o_result (t_result, nine Q16.16 + singular)
//
// One item enters every cycle; o_busy is held low, so a start is always taken.
// Each result follows its item through the cofactor lanes, the determinant
// products and sum, and the divider lanes, whose 32 restoring steps (one
// quotient bit per stage) set their depth.
// Reset (i_rst_n low, synchronous) drops all beats in flight.
// The receiver cannot stall; each result is shown for one cycle only.
module invert_3x3_matrix (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  inv3_pkg::t_item   i_item,
    output logic              o_done,
    output inv3_pkg::t_result o_result
);
    import inv3_pkg::*;

    logic signed [ENT_W-1:0] a [3][3];
    assign a[0][0] = i_item.e00; assign a[0][1] = i_item.e01; assign a[0][2] = i_item.e02;
    assign a[1][0] = i_item.e10; assign a[1][1] = i_item.e11; assign a[1][2] = i_item.e12;
    assign a[2][0] = i_item.e20; assign a[2][1] = i_item.e21; assign a[2][2] = i_item.e22;

    // nine cofactor lanes; the cyclic index form already carries the sign
    logic signed [COF_W-1:0] cof [3][3];
    for (genvar i = 0; i < 3; i++) begin : g_ci
        for (genvar j = 0; j < 3; j++) begin : g_cj
            localparam int I1 = (i + 1) % 3;
            localparam int I2 = (i + 2) % 3;
            localparam int J1 = (j + 1) % 3;
            localparam int J2 = (j + 2) % 3;
            inv3_cof u_cof (
                .i_clk (i_clk),
                .i_a   (a[I1][J1]),
                .i_b   (a[I2][J2]),
                .i_c   (a[I1][J2]),
                .i_d   (a[I2][J1]),
                .o_cof (cof[i][j])
            );
        end
    end

    // hold the first column until the cofactors are ready, and hold the
    // cofactors for the two determinant stages
    logic signed [ENT_W-1:0] r_col0_d1 [3];
    logic signed [ENT_W-1:0] r_col0_d2 [3];
    logic signed [COF_W-1:0] r_cof_d   [3][3];
    logic signed [COF_W-1:0] r_cof_d2  [3][3];
    logic signed [DET_W-1:0] r_prod    [3];
    logic signed [DET_W-1:0] r_det;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_col0_d1[i] <= a[i][0];
            r_col0_d2[i] <= r_col0_d1[i];
            r_prod[i]    <= DET_W'(r_col0_d2[i]) * DET_W'(cof[i][0]);
        end
        r_cof_d  <= cof;
        r_cof_d2 <= r_cof_d;
        r_det    <= r_prod[0] + r_prod[1] + r_prod[2];
    end

    // nine divider lanes: r(i,j) = C(j,i) / D
    logic [RES_W-1:0] q [3][3];
    for (genvar i = 0; i < 3; i++) begin : g_di
        for (genvar j = 0; j < 3; j++) begin : g_dj
            inv3_div u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_num   (r_cof_d2[j][i]),
                .i_den   (r_det),
                .o_q     (q[i][j])
            );
        end
    end

    // track beats in flight, and the zero determinant alongside the dividers
    logic [TOT_LAT-1:0] r_vld;
    logic [DIV_LAT-1:0] r_sing;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TOT_LAT-2:0], i_start & ~o_busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sing <= {r_sing[DIV_LAT-2:0], r_det == '0};
    end

    // merge lane outputs into one result beat
    assign o_busy   = 1'b0;
    assign o_done   = r_vld[TOT_LAT-1];
    assign o_result = '{r00: q[0][0], r01: q[0][1], r02: q[0][2],
                        r10: q[1][0], r11: q[1][1], r12: q[1][2],
                        r20: q[2][0], r21: q[2][1], r22: q[2][2],
                        singular: r_sing[DIV_LAT-1]};

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.singular) |-> (o_result.r00 == 0 && o_result.r11 == 0
            && o_result.r22 == 0 && o_result.r01 == 0 && o_result.r20 == 0))
        else $error("singular result carries nonzero entries");

    a_done_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_vld[TOT_LAT-2]))
        else $error("result beat without a matching item");

endmodule

/* dv/invert_3x3_matrix_tb.sv */
module invert_3x3_matrix_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import inv3_pkg::*;

    localparam int CYC_LIMIT = 200000;

    // Scoreboard: hold one expected inverse per accepted matrix, in order.
    class inverse_board;
        t_result pending_inverses[$];
        int      n_errors;

        static function automatic logic [31:0] div_saturate(longint num, longint den);
            longint unsigned n;
            longint unsigned d;
            longint unsigned q;
            bit              neg;
            n   = (num < 0 ? -num : num);
            n   = n << FRAC_SH;
            d   = (den < 0 ? -den : den);
            q   = n / d;
            neg = (num < 0) != (den < 0);
            if (neg) begin
                if (q >= 64'h8000_0000) return NEG_SAT;
                return 32'(-q);
            end
            if (q > 64'h7FFF_FFFF) return POS_SAT;
            return q[31:0];
        endfunction

        // Compute the inverse by cofactor expansion along column 0.
        static function automatic t_result invert(t_item m);
            longint  a [3][3];
            longint  cof [3][3];
            longint  det;
            logic [31:0] r [3][3];
            t_result res;
            a[0][0] = m.e00; a[0][1] = m.e01; a[0][2] = m.e02;
            a[1][0] = m.e10; a[1][1] = m.e11; a[1][2] = m.e12;
            a[2][0] = m.e20; a[2][1] = m.e21; a[2][2] = m.e22;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    cof[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
                              - a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
            det = a[0][0]*cof[0][0] + a[1][0]*cof[1][0] + a[2][0]*cof[2][0];
            res = '0;
            if (det == 0) begin
                res.singular = 1'b1;
                return res;
            end
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    r[i][j] = div_saturate(cof[j][i], det);
            res.r00 = r[0][0]; res.r01 = r[0][1]; res.r02 = r[0][2];
            res.r10 = r[1][0]; res.r11 = r[1][1]; res.r12 = r[1][2];
            res.r20 = r[2][0]; res.r21 = r[2][1]; res.r22 = r[2][2];
            return res;
        endfunction

        function void note_matrix(t_item m);
            pending_inverses.push_back(invert(m));
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t: mismatch %s got %h want %h", $realtime, what, got, want);
            n_errors++;
        endtask

        task check_inverse(t_result got);
            t_result want;
            if (pending_inverses.size() == 0) begin
                report("unexpected beat", 0, 0);
                return;
            end
            want = pending_inverses.pop_front();
            if (got.r00 !== want.r00) report("r00", got.r00, want.r00);
            if (got.r01 !== want.r01) report("r01", got.r01, want.r01);
            if (got.r02 !== want.r02) report("r02", got.r02, want.r02);
            if (got.r10 !== want.r10) report("r10", got.r10, want.r10);
            if (got.r11 !== want.r11) report("r11", got.r11, want.r11);
            if (got.r12 !== want.r12) report("r12", got.r12, want.r12);
            if (got.r20 !== want.r20) report("r20", got.r20, want.r20);
            if (got.r21 !== want.r21) report("r21", got.r21, want.r21);
            if (got.r22 !== want.r22) report("r22", got.r22, want.r22);
            if (got.singular !== want.singular)
                report("singular", 32'(got.singular), 32'(want.singular));
        endtask
    endclass

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_start = 1'b0;
    logic    o_busy;
    t_item   i_item = '0;
    logic    o_done;
    t_result o_result;

    inverse_board board = new();
    int           n_cycles;

    always #6 i_clk = ~i_clk;

    invert_3x3_matrix i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // Check each result beat at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) board.check_inverse(o_result);
    end

    // Bound the run; a hang ends as a failure.
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYC_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Present one matrix, hold start until accepted, then drop start if gap is nonzero.
    // Back-to-back beats keep start high with no lowering in between.
    task automatic send_matrix(t_item m, int gap);
        i_item  <= m;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        board.note_matrix(m);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [15:0] rand_entry();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($signed($urandom_range(0, 1024)) - 512);
            3:       return {{8{1'b0}}, 8'($urandom)} ^ ($urandom_range(0, 1) ? 16'hFFFF : 16'h0);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_item rand_matrix();
        t_item m;
        m = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
             rand_entry(), rand_entry(), rand_entry(), rand_entry()};
        // Copy a row or column sometimes to force a singular matrix.
        case ($urandom_range(0, 7))
            0: begin m.e10 = m.e00; m.e11 = m.e01; m.e12 = m.e02; end
            1: begin m.e02 = m.e00; m.e12 = m.e10; m.e22 = m.e20; end
            default: ;
        endcase
        return m;
    endfunction

    function automatic t_item diag(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        t_item m;
        m = '0;
        m.e00 = a; m.e11 = b; m.e22 = c;
        return m;
    endfunction

    task automatic wait_drain();
        while (board.pending_inverses.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_item m;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity, zero, extremes, tiny determinant, sign patterns.
        send_matrix(diag(16'h0100, 16'h0100, 16'h0100), 0);
        send_matrix('0, 0);
        send_matrix(diag(16'h8000, 16'h8000, 16'h8000), 1);
        send_matrix(diag(16'h7FFF, 16'h7FFF, 16'h7FFF), 0);
        send_matrix(diag(16'h0001, 16'h0001, 16'h0001), 0);   // large inverse, 256.0, no saturation
        send_matrix(diag(16'hFFFF, 16'h0001, 16'h0001), 2);   // mixed signs, r00 is -256.0
        send_matrix(diag(16'h0001, 16'h7FFF, 16'h8000), 0);
        send_matrix({9{16'h8000}}, 0);                        // singular, all equal
        send_matrix({9{16'h7FFF}}, 0);
        send_matrix({9{16'hFFFF}}, 3);
        m = '0; m.e02 = 16'h0100; m.e11 = 16'h0100; m.e20 = 16'h0100;
        send_matrix(m, 0);                                    // permutation
        m = '0; m.e01 = 16'h8000; m.e10 = 16'h7FFF; m.e22 = 16'h0200;
        send_matrix(m, 0);
        m = {16'h0100, 16'h0200, 16'h0300, 16'h0000, 16'h0100, 16'h0400,
             16'h0500, 16'h0600, 16'h0000};
        send_matrix(m, 0);                                    // full cofactor signs
        send_matrix(diag(16'h0100, 16'h0000, 16'h0100), 1);   // singular, zero pivot

        // Hold off until every expected inverse has come back.
        wait_drain();

        for (int k = 0; k < 800; k++) begin
            int gap;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
            if (k >= 300 && k < 400) gap = 0;   // sustained full-rate burst
            send_matrix(rand_matrix(), gap);
        end
        i_start <= 1'b0;

        wait_drain();
        repeat (TOT_LAT + 10) @(posedge i_clk);
        if (board.n_errors == 0 && board.pending_inverses.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
